/* hw/rtl/i2cee_pkg.sv */
// Shared types and constants for the I2C EEPROM slave model.
// No dependencies; used by the controller, the datapath and the top level.
package i2cee_pkg;

  localparam int unsigned DEV_ADDR_W = 7;
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned APB_DATA_W = 32;
  localparam int unsigned APB_ADDR_W = 3;

  localparam logic [DEV_ADDR_W-1:0] DEV_ADDR_RESET = 7'h60;

  // Register index, taken from paddr[2] (bits [1:0] select a byte lane).
  localparam logic REG_DEVICE_ADDRESS = 1'b0;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_READ  = 1'b1;

  // Controller to datapath.
  typedef struct packed {
    logic clear;     // write one zero word of the clearing pass
    logic accept;    // an input word is taken at this edge
    logic load_ram;  // capture RAM read data into the output register
  } ctrl_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic clear_last;  // clearing pass reaches its final entry
    logic exec_read;   // the offered word is an executed read
  } dp_sts_t;

endpackage

/* hw/rtl/i2cee_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module i2cee_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* hw/rtl/i2cee_ctrl.sv */
// Control state machine: clearing pass, word acceptance, read wait, output valid.
// Depends on i2cee_pkg.
module i2cee_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  output logic                  out_valid,
  input  logic                  out_stall,
  input  i2cee_pkg::dp_sts_t    sts,
  output i2cee_pkg::ctrl_cmd_t  cmd
);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RDWAIT
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    in_stall      = 1'b1;
    cmd           = '0;
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && out_stall;
    case (state_r)
      ST_CLEAR: begin
        cmd.clear = 1'b1;
        if (sts.clear_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_stall   = out_valid_r && out_stall;
        cmd.accept = in_valid && !in_stall;
        if (cmd.accept) begin
          // A read waits in ST_RDWAIT for the registered RAM read; every other word finishes now.
          if (sts.exec_read) begin
            state_nxt     = ST_RDWAIT;
            out_valid_nxt = 1'b0;
          end else begin
            out_valid_nxt = 1'b1;
          end
        end
      end
      ST_RDWAIT: begin
        cmd.load_ram  = 1'b1;
        out_valid_nxt = 1'b1;
        state_nxt     = ST_IDLE;
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

`ifndef SYNTHESIS
  a_read_loads_next: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.accept && sts.exec_read |=> cmd.load_ram)
    else $error("executed read not followed by RAM capture");

  a_ram_into_free_reg: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_ram |-> !out_valid_r)
    else $error("RAM data captured over a pending result");

  a_no_accept_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.accept |-> !(out_valid_r && out_stall))
    else $error("word accepted while the output register is held");

  a_no_accept_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clear |-> !cmd.accept && !cmd.load_ram)
    else $error("activity during the clearing pass");
`endif

endmodule

/* hw/rtl/i2cee_dp.sv */
// Datapath: device address register, pointer, abort flag, byte store and
// output register. Depends on i2cee_pkg and i2cee_ram.
module i2cee_dp #(
  parameter int unsigned MEM_DEPTH = 512
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  i2cee_pkg::ctrl_cmd_t                  cmd,
  output i2cee_pkg::dp_sts_t                    sts,
  input  logic [i2cee_pkg::DEV_ADDR_W-1:0]      in_target_address,
  input  logic                                  in_command,
  input  logic                                  in_first_of_transfer,
  input  logic                                  in_first_of_message,
  input  logic                                  in_has_byte,
  input  logic [i2cee_pkg::BYTE_W-1:0]          in_write_byte,
  output logic [i2cee_pkg::BYTE_W-1:0]          out_read_byte,
  output logic                                  out_status,
  input  logic                                  cfg_wr,
  input  logic [i2cee_pkg::APB_ADDR_W-1:0]      cfg_addr,
  input  logic [i2cee_pkg::APB_DATA_W-1:0]      cfg_wdata,
  output logic [i2cee_pkg::APB_DATA_W-1:0]      cfg_rdata
);

  localparam int unsigned PTR_W = $clog2(MEM_DEPTH);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(MEM_DEPTH - 1);

  logic [i2cee_pkg::DEV_ADDR_W-1:0] dev_addr_r, dev_addr_nxt;
  logic [PTR_W-1:0]                 ptr_r, ptr_nxt, ptr_inc;
  logic [PTR_W-1:0]                 clr_addr_r, clr_addr_nxt;
  logic                             abort_r, abort_nxt;
  logic [i2cee_pkg::BYTE_W-1:0]     rbyte_r, rbyte_nxt;
  logic                             status_r, status_nxt;

  logic                             abort_eff, match, exec;
  logic                             exec_read, exec_store, exec_load;
  logic                             ram_we, ram_re;
  logic [PTR_W-1:0]                 ram_waddr;
  logic [i2cee_pkg::BYTE_W-1:0]     ram_wdata, ram_rdata;
  logic                             reg_sel;

  // A transfer start clears the abort flag before the word is judged.
  assign abort_eff  = abort_r && !in_first_of_transfer;
  assign match      = (in_target_address == dev_addr_r);
  assign exec       = !abort_eff && match && in_has_byte;
  assign exec_read  = exec && (in_command == i2cee_pkg::CMD_READ);
  assign exec_load  = exec && (in_command == i2cee_pkg::CMD_WRITE) && in_first_of_message;
  assign exec_store = exec && (in_command == i2cee_pkg::CMD_WRITE) && !in_first_of_message;

  assign ptr_inc = (ptr_r == PTR_LAST) ? '0 : ptr_r + PTR_W'(1);

  assign sts.clear_last = (clr_addr_r == PTR_LAST);
  assign sts.exec_read  = exec_read;

  assign ram_we    = cmd.clear || (cmd.accept && exec_store);
  assign ram_waddr = cmd.clear ? clr_addr_r : ptr_r;
  assign ram_wdata = cmd.clear ? '0 : in_write_byte;
  assign ram_re    = cmd.accept && exec_read;

  i2cee_ram #(
    .WIDTH (i2cee_pkg::BYTE_W),
    .DEPTH (MEM_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ptr_r),
    .rdata (ram_rdata)
  );

  assign reg_sel = (cfg_addr[2] == i2cee_pkg::REG_DEVICE_ADDRESS);

  always_comb begin
    dev_addr_nxt = dev_addr_r;
    if (cfg_wr && reg_sel) begin
      dev_addr_nxt = cfg_wdata[i2cee_pkg::DEV_ADDR_W-1:0];
    end
    cfg_rdata = reg_sel ? i2cee_pkg::APB_DATA_W'(dev_addr_r) : '0;
  end

  always_comb begin
    ptr_nxt      = ptr_r;
    abort_nxt    = abort_r;
    clr_addr_nxt = clr_addr_r;
    rbyte_nxt    = rbyte_r;
    status_nxt   = status_r;
    if (cmd.clear) begin
      clr_addr_nxt = clr_addr_r + PTR_W'(1);
    end
    if (cmd.accept) begin
      abort_nxt  = abort_eff || !match;
      status_nxt = abort_eff || !match;
      rbyte_nxt  = '0;
      if (exec_load) begin
        // The byte is below the depth only if the depth is at least 256; the user must ensure it, the block does not.
        ptr_nxt = PTR_W'(in_write_byte);
      end else if (exec_read || exec_store) begin
        ptr_nxt = ptr_inc;
      end
    end
    if (cmd.load_ram) begin
      rbyte_nxt  = ram_rdata;
      status_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dev_addr_r <= i2cee_pkg::DEV_ADDR_RESET;
      ptr_r      <= '0;
      abort_r    <= 1'b0;
      clr_addr_r <= '0;
    end else begin
      dev_addr_r <= dev_addr_nxt;
      ptr_r      <= ptr_nxt;
      abort_r    <= abort_nxt;
      clr_addr_r <= clr_addr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rbyte_r  <= rbyte_nxt;
    status_r <= status_nxt;
  end

  assign out_read_byte = rbyte_r;
  assign out_status    = status_r;

endmodule

/* hw/rtl/i2c_eeprom_slave_model.sv */
// Top level of the I2C EEPROM slave model: APB register port and word channels.
// Depends on i2cee_pkg, i2cee_ctrl and i2cee_dp.

// Each input word is one byte slot of a bus message (or an empty message) and
// yields exactly one result word with the read byte and a status bit. After
// reset the byte store is cleared, one entry per cycle; no input word is taken
// until that pass is done, while register writes are taken throughout. Then a
// write, pointer load, empty message or rejected word is done when taken, so
// such words can follow each other every cycle while the output is not stalled.
// An executed read passes through a read wait state, set by the registered read
// port of the byte store; no input word is taken in that state. The device
// address register is at byte address 0, resets to 0x60; pready is always high.
module i2c_eeprom_slave_model #(
  parameter int unsigned MEM_DEPTH = 512
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [i2cee_pkg::DEV_ADDR_W-1:0]      in_target_address,
  input  logic                                  in_command,
  input  logic                                  in_first_of_transfer,
  input  logic                                  in_first_of_message,
  input  logic                                  in_has_byte,
  input  logic [i2cee_pkg::BYTE_W-1:0]          in_write_byte,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [i2cee_pkg::BYTE_W-1:0]          out_read_byte,
  output logic                                  out_status,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [i2cee_pkg::APB_ADDR_W-1:0]      paddr,
  input  logic [i2cee_pkg::APB_DATA_W-1:0]      pwdata,
  output logic [i2cee_pkg::APB_DATA_W-1:0]      prdata,
  output logic                                  pready
);

  i2cee_pkg::ctrl_cmd_t cmd;
  i2cee_pkg::dp_sts_t   sts;
  logic                 cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  i2cee_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  i2cee_dp #(
    .MEM_DEPTH (MEM_DEPTH)
  ) u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .sts                  (sts),
    .in_target_address    (in_target_address),
    .in_command           (in_command),
    .in_first_of_transfer (in_first_of_transfer),
    .in_first_of_message  (in_first_of_message),
    .in_has_byte          (in_has_byte),
    .in_write_byte        (in_write_byte),
    .out_read_byte        (out_read_byte),
    .out_status           (out_status),
    .cfg_wr               (cfg_wr),
    .cfg_addr             (paddr),
    .cfg_wdata            (pwdata),
    .cfg_rdata            (prdata)
  );

endmodule
